@@ design/jdq_pkg.sv @@
// Package for the joint distribution query core.
// Holds the shared widths, codes, state and divider-select types, and the command
// and status structs between controller and datapath. Depends on nothing.
package jdq_pkg;

    localparam int COUNT_W   = 32;
    localparam int IDX_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = COUNT_W + SIZE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_FLUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DIV_JOINT,
        DIV_IN_MARG,
        DIV_OUT_MARG,
        DIV_IN_COND,
        DIV_OUT_COND
    } div_sel_t;

    typedef struct packed {
        logic load_we;
        logic query_start;
        logic sweep_clear;
        logic row_rd;
        logic col_rd;
        logic div_start;
        logic div_store;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic query_err;
        logic row_last;
        logic col_last;
        logic div_done;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

@@ design/jdq_divider.sv @@
// Restoring fractional divider: floor(num * 2^F / den), saturated at 2^F.
// One quotient bit per cycle. Depends on jdq_pkg.
module jdq_divider #(
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [jdq_pkg::SUM_W-1:0]    num,
    input  logic [jdq_pkg::SUM_W-1:0]    den,
    output logic                         done,
    output logic [PROB_FRAC_BITS:0]      quotient
);

    localparam int CNT_W = $clog2(PROB_FRAC_BITS + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [jdq_pkg::SUM_W-1:0]   rem_reg;
    logic [jdq_pkg::SUM_W-1:0]   den_reg;
    logic [PROB_FRAC_BITS:0]     q_reg;
    logic [jdq_pkg::SUM_W:0]     rem_shift;
    logic                        ge;
    logic [jdq_pkg::SUM_W-1:0]   rem_next;

    assign rem_shift = {rem_reg, 1'b0};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_next  = ge ? jdq_pkg::SUM_W'(rem_shift - {1'b0, den_reg})
                          : rem_shift[jdq_pkg::SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (num >= den) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= num;
            cnt_reg <= CNT_W'(PROB_FRAC_BITS);
            if (num >= den) begin
                q_reg <= {1'b1, {PROB_FRAC_BITS{1'b0}}};
            end else begin
                q_reg <= '0;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
            q_reg   <= {q_reg[PROB_FRAC_BITS-1:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ design/jdq_datapath.sv @@
// Datapath: configuration registers, count memory, row and column sums,
// the shared divider and the result and output registers. Depends on jdq_pkg.
module jdq_datapath #(
    parameter int MAX_DOMAIN     = 64,
    parameter int MAX_RANGE      = 64,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [jdq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jdq_pkg::COUNT_W-1:0]       cfg_wr_data,
    input  logic                              s_kind,
    input  logic [jdq_pkg::IDX_W-1:0]         s_in_index,
    input  logic [jdq_pkg::IDX_W-1:0]         s_out_index,
    input  logic [jdq_pkg::COUNT_W-1:0]       s_count_value,
    input  jdq_pkg::cmd_t                     cmd,
    output jdq_pkg::sts_t                     sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [PROB_FRAC_BITS:0]           m_joint_prob,
    output logic [PROB_FRAC_BITS:0]           m_input_marginal,
    output logic [PROB_FRAC_BITS:0]           m_output_marginal,
    output logic [PROB_FRAC_BITS:0]           m_input_conditional,
    output logic [PROB_FRAC_BITS:0]           m_output_conditional,
    output logic                              m_total_zero,
    output logic                              m_column_zero,
    output logic                              m_row_zero,
    output logic                              m_index_error
);

    localparam int DEPTH  = MAX_DOMAIN * MAX_RANGE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIN_W  = $clog2(MAX_RANGE + 1) + 8;
    localparam int SW     = jdq_pkg::SUM_W;
    localparam int QW     = PROB_FRAC_BITS + 1;

    logic [jdq_pkg::SIZE_W-1:0]  domain_size_reg;
    logic [jdq_pkg::SIZE_W-1:0]  range_size_reg;
    logic [jdq_pkg::COUNT_W-1:0] total_count_reg;
    logic [jdq_pkg::SIZE_W-1:0]  rows;
    logic [jdq_pkg::SIZE_W-1:0]  cols;

    logic [jdq_pkg::COUNT_W-1:0] count_mem [DEPTH];
    logic [jdq_pkg::COUNT_W-1:0] rd_data_reg;
    logic [LIN_W-1:0]            wr_lin;
    logic [LIN_W-1:0]            rd_lin;
    logic                        load_ok;

    logic [jdq_pkg::IDX_W-1:0]   row_reg;
    logic [jdq_pkg::IDX_W-1:0]   col_reg;
    logic [jdq_pkg::SIZE_W-1:0]  idx_reg;
    logic                        rd_row_reg;
    logic                        rd_col_reg;
    logic                        rd_pair_reg;
    logic [SW-1:0]               rsum_reg;
    logic [SW-1:0]               csum_reg;
    logic [SW-1:0]               pair_reg;

    jdq_pkg::div_sel_t           div_sel_reg;
    logic [SW-1:0]               div_num;
    logic [SW-1:0]               div_den;
    logic                        div_done;
    logic [QW-1:0]               div_q;

    logic [QW-1:0] joint_reg, in_marg_reg, out_marg_reg, in_cond_reg, out_cond_reg;
    logic          tz_reg, cz_reg, rz_reg, ie_reg;
    logic          m_valid_reg;
    logic          m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            domain_size_reg <= jdq_pkg::SIZE_W'(64);
            range_size_reg  <= jdq_pkg::SIZE_W'(64);
            total_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                jdq_pkg::CFG_DOMAIN_SIZE: domain_size_reg <= cfg_wr_data[jdq_pkg::SIZE_W-1:0];
                jdq_pkg::CFG_RANGE_SIZE:  range_size_reg  <= cfg_wr_data[jdq_pkg::SIZE_W-1:0];
                jdq_pkg::CFG_TOTAL_COUNT: total_count_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign rows = (32'(domain_size_reg) > 32'(MAX_DOMAIN)) ? jdq_pkg::SIZE_W'(MAX_DOMAIN)
                                                          : domain_size_reg;
    assign cols = (32'(range_size_reg) > 32'(MAX_RANGE)) ? jdq_pkg::SIZE_W'(MAX_RANGE)
                                                        : range_size_reg;

    assign sts.query_err = ({1'b0, s_in_index} >= rows) || ({1'b0, s_out_index} >= cols);
    assign load_ok = (32'(s_in_index) < 32'(MAX_DOMAIN)) && (32'(s_out_index) < 32'(MAX_RANGE));
    assign wr_lin  = LIN_W'(s_in_index) * LIN_W'(MAX_RANGE) + LIN_W'(s_out_index);
    assign rd_lin  = cmd.row_rd ? LIN_W'(row_reg) * LIN_W'(MAX_RANGE) + LIN_W'(idx_reg)
                                : LIN_W'(idx_reg) * LIN_W'(MAX_RANGE) + LIN_W'(col_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_we && s_kind == jdq_pkg::KIND_LOAD && load_ok) begin
            count_mem[ADDR_W'(wr_lin)] <= s_count_value;
        end
        if (cmd.row_rd || cmd.col_rd) begin
            rd_data_reg <= count_mem[ADDR_W'(rd_lin)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_row_reg  <= 1'b0;
            rd_col_reg  <= 1'b0;
            rd_pair_reg <= 1'b0;
            idx_reg     <= '0;
            div_sel_reg <= jdq_pkg::DIV_JOINT;
        end else begin
            rd_row_reg  <= cmd.row_rd;
            rd_col_reg  <= cmd.col_rd;
            rd_pair_reg <= cmd.row_rd && (idx_reg == {1'b0, col_reg});
            if (cmd.query_start || cmd.sweep_clear) begin
                idx_reg <= '0;
            end else if (cmd.row_rd || cmd.col_rd) begin
                idx_reg <= idx_reg + jdq_pkg::SIZE_W'(1);
            end
            if (cmd.query_start) begin
                div_sel_reg <= jdq_pkg::DIV_JOINT;
            end else if (cmd.div_store) begin
                div_sel_reg <= jdq_pkg::div_sel_t'(div_sel_reg + 3'd1);
            end
        end
    end

    assign sts.row_last = idx_reg == cols - jdq_pkg::SIZE_W'(1);
    assign sts.col_last = idx_reg == rows - jdq_pkg::SIZE_W'(1);
    assign sts.div_done = div_done;
    assign sts.div_last = div_sel_reg == jdq_pkg::DIV_OUT_COND;

    always_ff @(posedge aclk) begin
        if (cmd.query_start) begin
            row_reg  <= s_in_index;
            col_reg  <= s_out_index;
            rsum_reg <= '0;
            csum_reg <= '0;
        end else begin
            if (rd_row_reg) begin
                rsum_reg <= rsum_reg + SW'(rd_data_reg);
            end
            if (rd_col_reg) begin
                csum_reg <= csum_reg + SW'(rd_data_reg);
            end
        end
        if (rd_pair_reg) begin
            pair_reg <= SW'(rd_data_reg);
        end
    end

    always_comb begin
        case (div_sel_reg)
            jdq_pkg::DIV_JOINT:    begin div_num = pair_reg; div_den = SW'(total_count_reg); end
            jdq_pkg::DIV_IN_MARG:  begin div_num = rsum_reg; div_den = SW'(total_count_reg); end
            jdq_pkg::DIV_OUT_MARG: begin div_num = csum_reg; div_den = SW'(total_count_reg); end
            jdq_pkg::DIV_IN_COND:  begin div_num = pair_reg; div_den = csum_reg; end
            jdq_pkg::DIV_OUT_COND: begin div_num = pair_reg; div_den = rsum_reg; end
            default:               begin div_num = pair_reg; div_den = rsum_reg; end
        endcase
    end

    jdq_divider #(
        .PROB_FRAC_BITS(PROB_FRAC_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.query_start) begin
            joint_reg    <= '0;
            in_marg_reg  <= '0;
            out_marg_reg <= '0;
            in_cond_reg  <= '0;
            out_cond_reg <= '0;
            tz_reg       <= 1'b0;
            cz_reg       <= 1'b0;
            rz_reg       <= 1'b0;
            ie_reg       <= sts.query_err;
        end else begin
            if (cmd.div_start) begin
                tz_reg <= total_count_reg == '0;
                cz_reg <= csum_reg == '0;
                rz_reg <= rsum_reg == '0;
            end
            if (cmd.div_store && div_den != '0) begin
                case (div_sel_reg)
                    jdq_pkg::DIV_JOINT:    joint_reg    <= div_q;
                    jdq_pkg::DIV_IN_MARG:  in_marg_reg  <= div_q;
                    jdq_pkg::DIV_OUT_MARG: out_marg_reg <= div_q;
                    jdq_pkg::DIV_IN_COND:  in_cond_reg  <= div_q;
                    jdq_pkg::DIV_OUT_COND: out_cond_reg <= div_q;
                    default: ;
                endcase
            end
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_joint_prob         <= joint_reg;
            m_input_marginal     <= in_marg_reg;
            m_output_marginal    <= out_marg_reg;
            m_input_conditional  <= in_cond_reg;
            m_output_conditional <= out_cond_reg;
            m_total_zero         <= tz_reg;
            m_column_zero        <= cz_reg;
            m_row_zero           <= rz_reg;
            m_index_error        <= ie_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ design/jdq_controller.sv @@
// Controller state machine: sequences loads, the row and column sweeps,
// the five divisions and the hand-off to the output register. Depends on jdq_pkg.
module jdq_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_kind,
    input  jdq_pkg::sts_t  sts,
    output jdq_pkg::cmd_t  cmd
);

    jdq_pkg::state_t state_reg;
    jdq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jdq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jdq_pkg::ST_IDLE: begin
                if (s_valid && s_kind == jdq_pkg::KIND_QUERY) begin
                    state_next = sts.query_err ? jdq_pkg::ST_OUT : jdq_pkg::ST_ROW;
                end
            end
            jdq_pkg::ST_ROW: begin
                if (sts.row_last) begin
                    state_next = jdq_pkg::ST_COL;
                end
            end
            jdq_pkg::ST_COL: begin
                if (sts.col_last) begin
                    state_next = jdq_pkg::ST_FLUSH;
                end
            end
            jdq_pkg::ST_FLUSH:     state_next = jdq_pkg::ST_DIV_START;
            jdq_pkg::ST_DIV_START: state_next = jdq_pkg::ST_DIV_WAIT;
            jdq_pkg::ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = sts.div_last ? jdq_pkg::ST_OUT : jdq_pkg::ST_DIV_START;
                end
            end
            jdq_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    state_next = jdq_pkg::ST_IDLE;
                end
            end
            default: state_next = jdq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            jdq_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.load_we     = s_valid && s_kind == jdq_pkg::KIND_LOAD;
                cmd.query_start = s_valid && s_kind == jdq_pkg::KIND_QUERY;
            end
            jdq_pkg::ST_ROW: begin
                cmd.row_rd      = 1'b1;
                cmd.sweep_clear = sts.row_last;
            end
            jdq_pkg::ST_COL:       cmd.col_rd    = 1'b1;
            jdq_pkg::ST_FLUSH:     ;
            jdq_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            jdq_pkg::ST_DIV_WAIT:  cmd.div_store = sts.div_done;
            jdq_pkg::ST_OUT:       cmd.out_load  = sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ design/joint_distribution_query_core.sv @@
// Top level of the joint distribution query core: controller plus datapath.
// Depends on jdq_pkg, jdq_controller, jdq_datapath and jdq_divider.
//
// A load request writes one 32-bit count into the MAX_DOMAIN x MAX_RANGE count memory.
// A query request reads one entry per cycle from the single memory port, first the
// range_size entries of its row, then the domain_size entries of its column, then runs
// five fractional divisions one after another through one shared divider that produces
// one quotient bit per cycle. A division whose quotient saturates or whose divisor is
// zero finishes without the bit-by-bit steps, and a query with an index outside the
// configured sizes skips the sweeps and divisions and goes straight to the output. The
// count memory is not cleared at reset; every entry a query touches must be loaded
// first. Loads are taken while a finished result still waits on the output.
module joint_distribution_query_core #(
    parameter int MAX_DOMAIN     = 64,
    parameter int MAX_RANGE      = 64,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [jdq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jdq_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [jdq_pkg::IDX_W-1:0]       s_in_index,
    input  logic [jdq_pkg::IDX_W-1:0]       s_out_index,
    input  logic [jdq_pkg::COUNT_W-1:0]     s_count_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [PROB_FRAC_BITS:0]         m_joint_prob,
    output logic [PROB_FRAC_BITS:0]         m_input_marginal,
    output logic [PROB_FRAC_BITS:0]         m_output_marginal,
    output logic [PROB_FRAC_BITS:0]         m_input_conditional,
    output logic [PROB_FRAC_BITS:0]         m_output_conditional,
    output logic                            m_total_zero,
    output logic                            m_column_zero,
    output logic                            m_row_zero,
    output logic                            m_index_error
);

    localparam logic [PROB_FRAC_BITS:0] ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

    jdq_pkg::cmd_t cmd;
    jdq_pkg::sts_t sts;

    jdq_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    jdq_datapath #(
        .MAX_DOMAIN     (MAX_DOMAIN),
        .MAX_RANGE      (MAX_RANGE),
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wr_data          (cfg_wr_data),
        .s_kind               (s_kind),
        .s_in_index           (s_in_index),
        .s_out_index          (s_out_index),
        .s_count_value        (s_count_value),
        .cmd                  (cmd),
        .sts                  (sts),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_joint_prob         (m_joint_prob),
        .m_input_marginal     (m_input_marginal),
        .m_output_marginal    (m_output_marginal),
        .m_input_conditional  (m_input_conditional),
        .m_output_conditional (m_output_conditional),
        .m_total_zero         (m_total_zero),
        .m_column_zero        (m_column_zero),
        .m_row_zero           (m_row_zero),
        .m_index_error        (m_index_error)
    );

    // A load request never produces a result.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == jdq_pkg::KIND_LOAD |=> !$rose(m_valid))
        else $error("result appeared after a load request");

    // An index error reports all values and the other flags as zero.
    a_index_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_joint_prob == '0 && m_input_marginal == '0 &&
            m_output_marginal == '0 && m_input_conditional == '0 &&
            m_output_conditional == '0 && !m_total_zero && !m_column_zero && !m_row_zero)
        else $error("index error result carries nonzero fields");

    // A zero total zeroes every value divided by it.
    a_total_zero_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_total_zero |-> m_joint_prob == '0 && m_input_marginal == '0 &&
            m_output_marginal == '0)
        else $error("nonzero probability with zero total");

    // Every value saturates at one.
    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_joint_prob <= ONE && m_input_marginal <= ONE &&
            m_output_marginal <= ONE && m_input_conditional <= ONE &&
            m_output_conditional <= ONE)
        else $error("result above one");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for joint_distribution_query_core: loads count entries, sends
// queries and checks every result against a probability-table predictor kept in this file.
// Depends on jdq_pkg and the core RTL.
module tb_top;

    localparam int FRAC_BITS      = 16;
    localparam int TABLE_DIM      = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int EPOCH_ITEMS    = 28;
    localparam logic [jdq_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef logic [FRAC_BITS:0] prob_t;
    typedef logic [jdq_pkg::IDX_W-1:0] sym_t;

    localparam prob_t PROB_ONE = prob_t'(1) << FRAC_BITS;

    typedef struct packed {
        prob_t joint_prob;
        prob_t input_marginal;
        prob_t output_marginal;
        prob_t input_conditional;
        prob_t output_conditional;
        logic  total_zero;
        logic  column_zero;
        logic  row_zero;
        logic  index_error;
    } query_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [jdq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [jdq_pkg::COUNT_W-1:0]   cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_kind;
    sym_t                          s_in_index;
    sym_t                          s_out_index;
    logic [jdq_pkg::COUNT_W-1:0]   s_count_value;
    logic                          m_valid;
    logic                          m_ready;
    prob_t                         m_joint_prob;
    prob_t                         m_input_marginal;
    prob_t                         m_output_marginal;
    prob_t                         m_input_conditional;
    prob_t                         m_output_conditional;
    logic                          m_total_zero;
    logic                          m_column_zero;
    logic                          m_row_zero;
    logic                          m_index_error;

    logic [jdq_pkg::COUNT_W-1:0] count_tbl [TABLE_DIM][TABLE_DIM];
    bit                          loaded [TABLE_DIM][TABLE_DIM];
    logic [jdq_pkg::SIZE_W-1:0]  domain_cfg;
    logic [jdq_pkg::SIZE_W-1:0]  range_cfg;
    logic [jdq_pkg::COUNT_W-1:0] total_cfg;
    query_result_t               pending_answers[$];
    int                          mismatches;
    int                          requests_sent;
    int                          src_idle_pct;
    int                          sink_stall_pct;

    joint_distribution_query_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_in_index          (s_in_index),
        .s_out_index         (s_out_index),
        .s_count_value       (s_count_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_joint_prob        (m_joint_prob),
        .m_input_marginal    (m_input_marginal),
        .m_output_marginal   (m_output_marginal),
        .m_input_conditional (m_input_conditional),
        .m_output_conditional(m_output_conditional),
        .m_total_zero        (m_total_zero),
        .m_column_zero       (m_column_zero),
        .m_row_zero          (m_row_zero),
        .m_index_error       (m_index_error)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int rows_in_use();
        return (int'(domain_cfg) > TABLE_DIM) ? TABLE_DIM : int'(domain_cfg);
    endfunction

    function automatic int cols_in_use();
        return (int'(range_cfg) > TABLE_DIM) ? TABLE_DIM : int'(range_cfg);
    endfunction

    // Floored num / den in unsigned Q1.FRAC_BITS, saturated at one.
    function automatic prob_t fixed_ratio(longint unsigned num, longint unsigned den);
        if (num >= den) begin
            return PROB_ONE;
        end
        return prob_t'((num << FRAC_BITS) / den);
    endfunction

    function automatic query_result_t query_answer(sym_t row, sym_t col);
        query_result_t   ans;
        int              rows;
        int              cols;
        longint unsigned pair;
        longint unsigned row_sum;
        longint unsigned col_sum;
        longint unsigned total;
        ans = '0;
        rows = rows_in_use();
        cols = cols_in_use();
        if (int'(row) >= rows || int'(col) >= cols) begin
            ans.index_error = 1'b1;
            return ans;
        end
        pair = 64'(count_tbl[row][col]);
        total = 64'(total_cfg);
        row_sum = 0;
        col_sum = 0;
        for (int i = 0; i < cols; i++) begin
            row_sum += 64'(count_tbl[row][i]);
        end
        for (int i = 0; i < rows; i++) begin
            col_sum += 64'(count_tbl[i][col]);
        end
        if (total == 0) begin
            ans.total_zero = 1'b1;
        end else begin
            ans.joint_prob      = fixed_ratio(pair, total);
            ans.input_marginal  = fixed_ratio(row_sum, total);
            ans.output_marginal = fixed_ratio(col_sum, total);
        end
        if (col_sum == 0) begin
            ans.column_zero = 1'b1;
        end else begin
            ans.input_conditional = fixed_ratio(pair, col_sum);
        end
        if (row_sum == 0) begin
            ans.row_zero = 1'b1;
        end else begin
            ans.output_conditional = fixed_ratio(pair, row_sum);
        end
        return ans;
    endfunction

    function automatic string describe(query_result_t r);
        return $sformatf({"joint=%0d in_marg=%0d out_marg=%0d in_cond=%0d out_cond=%0d",
                          " tz=%0b cz=%0b rz=%0b ie=%0b"},
            r.joint_prob, r.input_marginal, r.output_marginal, r.input_conditional,
            r.output_conditional, r.total_zero, r.column_zero, r.row_zero, r.index_error);
    endfunction

    function automatic logic [jdq_pkg::COUNT_W-1:0] rand_count();
        case ($urandom_range(9))
            0, 1:    return '0;
            2, 3, 4: return jdq_pkg::COUNT_W'($urandom_range(255));
            5, 6:    return jdq_pkg::COUNT_W'($urandom_range(65535));
            7, 8:    return jdq_pkg::COUNT_W'($urandom);
            default: return '1;
        endcase
    endfunction

    function automatic logic [jdq_pkg::COUNT_W-1:0] rand_total();
        case ($urandom_range(7))
            0:       return '0;
            1:       return jdq_pkg::COUNT_W'(1);
            2:       return '1;
            3:       return jdq_pkg::COUNT_W'($urandom);
            4:       return jdq_pkg::COUNT_W'($urandom_range(1 << 20, 1));
            default: return jdq_pkg::COUNT_W'($urandom_range(4000, 1));
        endcase
    endfunction

    function automatic int unloaded_for(sym_t row, sym_t col, int rows, int cols);
        int n;
        n = 0;
        for (int i = 0; i < cols; i++) begin
            if (!loaded[row][i]) n++;
        end
        for (int i = 0; i < rows; i++) begin
            if (!loaded[i][col]) n++;
        end
        return n;
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        query_result_t seen;
        query_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_joint_prob, m_input_marginal, m_output_marginal, m_input_conditional,
                    m_output_conditional, m_total_zero, m_column_zero, m_row_zero,
                    m_index_error};
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: %s", describe(seen));
                end
            end else begin
                want = pending_answers.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 describe(want), describe(seen));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(input logic kind, input sym_t row, input sym_t col,
                                input logic [jdq_pkg::COUNT_W-1:0] cnt);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_in_index    <= row;
        s_out_index   <= col;
        s_count_value <= cnt;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (kind == jdq_pkg::KIND_LOAD) begin
            count_tbl[row][col] = cnt;
            loaded[row][col] = 1'b1;
        end else begin
            pending_answers.push_back(query_answer(row, col));
        end
    endtask

    // Loads leave no result behind, so an extra idle wait after the last result covers one still in flight.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [jdq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [jdq_pkg::COUNT_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            jdq_pkg::CFG_DOMAIN_SIZE: domain_cfg = data[jdq_pkg::SIZE_W-1:0];
            jdq_pkg::CFG_RANGE_SIZE:  range_cfg  = data[jdq_pkg::SIZE_W-1:0];
            jdq_pkg::CFG_TOTAL_COUNT: total_cfg  = data;
            default: ;
        endcase
    endtask

    task automatic configure(input int domain, input int rng,
                             input logic [jdq_pkg::COUNT_W-1:0] total);
        settle();
        write_register(jdq_pkg::CFG_DOMAIN_SIZE, jdq_pkg::COUNT_W'(domain));
        write_register(jdq_pkg::CFG_RANGE_SIZE, jdq_pkg::COUNT_W'(rng));
        write_register(jdq_pkg::CFG_TOTAL_COUNT, total);
    endtask

    task automatic test_zero_divisors();
        configure(2, 2, '0);
        send_request(jdq_pkg::KIND_LOAD, 0, 0, '0);
        send_request(jdq_pkg::KIND_LOAD, 0, 1, '0);
        send_request(jdq_pkg::KIND_LOAD, 1, 0, '0);
        send_request(jdq_pkg::KIND_LOAD, 1, 1, 32'd7);
        send_request(jdq_pkg::KIND_QUERY, 0, 0, '1);
        send_request(jdq_pkg::KIND_QUERY, 1, 1, '0);
    endtask

    task automatic test_saturation();
        configure(2, 2, 32'd5);
        send_request(jdq_pkg::KIND_LOAD, 1, 0, '1);
        send_request(jdq_pkg::KIND_QUERY, 0, 1, '0);
        send_request(jdq_pkg::KIND_QUERY, 1, 0, '0);
        send_request(jdq_pkg::KIND_QUERY, 0, 0, '0);
    endtask

    task automatic test_extreme_totals();
        configure(2, 2, 32'd1);
        send_request(jdq_pkg::KIND_QUERY, 1, 1, '0);
        configure(2, 2, '1);
        send_request(jdq_pkg::KIND_QUERY, 1, 0, '0);
    endtask

    task automatic test_index_errors();
        configure(2, 2, 32'd5);
        send_request(jdq_pkg::KIND_QUERY, 2, 0, '0);
        send_request(jdq_pkg::KIND_QUERY, 0, 2, '0);
        send_request(jdq_pkg::KIND_QUERY, 63, 63, '1);
        configure(0, 2, 32'd5);
        send_request(jdq_pkg::KIND_QUERY, 0, 0, '0);
    endtask

    // Size registers keep only their low seven bits; the spare index must change nothing.
    task automatic test_register_masking();
        settle();
        write_register(jdq_pkg::CFG_DOMAIN_SIZE, 32'hFFFF_FF82);
        write_register(jdq_pkg::CFG_RANGE_SIZE, 32'h0000_0181);
        write_register(jdq_pkg::CFG_TOTAL_COUNT, 32'd9);
        write_register(CFG_UNMAPPED, '1);
        send_request(jdq_pkg::KIND_QUERY, 1, 0, '0);
        send_request(jdq_pkg::KIND_QUERY, 0, 1, '0);
    endtask

    task automatic run_epoch(input int budget);
        int   stop;
        int   rows;
        int   cols;
        int   roll;
        int   cost;
        int   best_cost;
        sym_t r;
        sym_t c;
        sym_t br;
        sym_t bc;
        stop = requests_sent + budget;
        rows = rows_in_use();
        cols = cols_in_use();
        while (requests_sent < stop) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                if (roll < 20 && rows > 0 && cols > 0) begin
                    r = sym_t'($urandom_range(rows - 1));
                    c = sym_t'($urandom_range(cols - 1));
                end else begin
                    r = sym_t'($urandom_range(TABLE_DIM - 1));
                    c = sym_t'($urandom_range(TABLE_DIM - 1));
                end
                send_request(jdq_pkg::KIND_LOAD, r, c, rand_count());
            end else if (roll < 42 && (rows < TABLE_DIM || cols < TABLE_DIM)) begin
                if (rows < TABLE_DIM && (cols == TABLE_DIM || $urandom_range(1) == 0)) begin
                    r = sym_t'($urandom_range(TABLE_DIM - 1, rows));
                    c = sym_t'($urandom_range(TABLE_DIM - 1));
                end else begin
                    r = sym_t'($urandom_range(TABLE_DIM - 1));
                    c = sym_t'($urandom_range(TABLE_DIM - 1, cols));
                end
                send_request(jdq_pkg::KIND_QUERY, r, c, jdq_pkg::COUNT_W'($urandom));
            end else if (rows == 0 || cols == 0) begin
                send_request(jdq_pkg::KIND_QUERY, sym_t'($urandom_range(TABLE_DIM - 1)),
                             sym_t'($urandom_range(TABLE_DIM - 1)),
                             jdq_pkg::COUNT_W'($urandom));
            end else begin
                // Prefer the pair that needs the fewest fresh loads before it can be queried.
                best_cost = -1;
                repeat (3) begin
                    r = sym_t'($urandom_range(rows - 1));
                    c = sym_t'($urandom_range(cols - 1));
                    cost = unloaded_for(r, c, rows, cols);
                    if (best_cost < 0 || cost < best_cost) begin
                        best_cost = cost;
                        br = r;
                        bc = c;
                    end
                end
                for (int i = 0; i < cols; i++) begin
                    if (!loaded[br][i]) begin
                        send_request(jdq_pkg::KIND_LOAD, br, sym_t'(i), rand_count());
                    end
                end
                for (int i = 0; i < rows; i++) begin
                    if (!loaded[i][bc]) begin
                        send_request(jdq_pkg::KIND_LOAD, sym_t'(i), bc, rand_count());
                    end
                end
                send_request(jdq_pkg::KIND_QUERY, br, bc, jdq_pkg::COUNT_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int domain;
        int rng;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 51;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 51;
                end
                default: begin
                    src_idle_pct = 37;
                    sink_stall_pct = 37;
                end
            endcase
            for (int e = 0; e < 6; e++) begin
                domain = $urandom_range(8, 1);
                rng = $urandom_range(8, 1);
                case (e)
                    0: begin
                        domain = ($urandom_range(1) == 0) ? 64 : $urandom_range(127, 65);
                        rng = (mode == 3) ? 127 : $urandom_range(4, 1);
                    end
                    1: begin
                        domain = $urandom_range(4, 1);
                        rng = ($urandom_range(1) == 0) ? 127 : $urandom_range(126, 64);
                    end
                    2: begin
                        if (mode % 2 == 0) domain = 0;
                        else rng = 0;
                    end
                    3: begin
                        domain = 1;
                    end
                    default: ;
                endcase
                configure(domain, rng, rand_total());
                run_epoch(EPOCH_ITEMS);
            end
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= jdq_pkg::CFG_DOMAIN_SIZE;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_kind        <= jdq_pkg::KIND_LOAD;
        s_in_index    <= '0;
        s_out_index   <= '0;
        s_count_value <= '0;
        domain_cfg     = jdq_pkg::SIZE_W'(64);
        range_cfg      = jdq_pkg::SIZE_W'(64);
        total_cfg      = '0;
        mismatches     = 0;
        requests_sent  = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_divisors();
        test_saturation();
        test_extreme_totals();
        test_index_errors();
        test_register_masking();
        test_random_traffic();

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
